### src/assert_macros.svh
// assertion macros used by the checker file dmc_checker.sv
// no dependencies; the including module must have clk and rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CHK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define CHK_NEVER(label, cond, msg) \
  `CHK_ASSERT(label, !(cond), msg)

`endif

### src/dmc_pkg.sv
// types and constants of the delta-modulation sample channel
// no dependencies
package dmc_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2
  } opcode_t;

  // register indexes, byte address is 4 times the index
  localparam logic [2:0] REG_SAMPLE_ADDR   = 3'd0;
  localparam logic [2:0] REG_SAMPLE_LEN    = 3'd1;
  localparam logic [2:0] REG_LOOP_MODE     = 3'd2;
  localparam logic [2:0] REG_IRQ_ENABLE    = 3'd3;
  localparam logic [2:0] REG_PERIOD_RELOAD = 3'd4;

  localparam logic [8:0] PERIOD_RESET = 9'd428;
  localparam logic [2:0] DMA_CYCLES   = 3'd4;
  localparam logic [15:0] BUS_HIGH    = 16'h8000;

  typedef struct packed {
    logic [11:0] bytes_left;
    logic [14:0] read_pointer;
    logic [2:0]  dma_delay;
    logic [7:0]  fetched_byte;
    logic        fetched_valid;
    logic [7:0]  shift_byte;
    logic        shift_valid;
    logic [2:0]  bit_index;
    logic [8:0]  period_left;
    logic [6:0]  dac_value;
    logic        irq_pending;
    logic        stall_hold;
    logic        addr_drive;
  } dmc_state_t;

  // everything clear except the period counter
  localparam dmc_state_t STATE_RESET = '{period_left: PERIOD_RESET, default: '0};

  typedef struct packed {
    logic        busy_res;
    logic        irq_flag;
    logic [15:0] dma_addr;
    logic        dma_addr_valid;
    logic        cpu_stall;
    logic [6:0]  dac_level;
  } dmc_result_t;

endpackage

### src/delta_modulation_sample_channel_core.sv
// delta-modulation sample channel: dma fetch, shift unit and 7-bit dac
// depends on dmc_pkg
//
// channel  | group                       | payload
// input    | s_tvalid s_tready s_tuser   | tuser: opcode; tdata: mem_data
// result   | m_tvalid m_tready m_tdata   | dac, stall, addr valid, addr, irq, busy
// config   | psel penable pwrite paddr   | five registers at 0x00..0x10
//
// one item per cycle while no result waits: the state update is one combinational pass between the
// state register and the result register, so a new item can enter each cycle
// s_tready drops only while a result waits and m_tready is low
// synchronous active-high reset clears state; period counter resets to 428
module delta_modulation_sample_channel_core
  import dmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] mem_data
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  // [6:0] dac_level, [7] cpu_stall, [8] dma_addr_valid, [24:9] dma_addr,
  // [25] irq_flag, [26] busy_res, [31:27] zero
  output logic [31:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] sample_addr_latch;
  logic [7:0] sample_len_latch;
  logic       loop_mode;
  logic       irq_enable;
  logic [8:0] period_reload;

  dmc_state_t  st, st_next;
  dmc_result_t res_next;
  logic        in_xfer;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_addr_latch <= '0;
      sample_len_latch  <= '0;
      loop_mode         <= 1'b0;
      irq_enable        <= 1'b0;
      period_reload     <= PERIOD_RESET;
    end else if (cfg_write) begin
      case (paddr[4:2])
        REG_SAMPLE_ADDR:   sample_addr_latch <= pwdata[7:0];
        REG_SAMPLE_LEN:    sample_len_latch  <= pwdata[7:0];
        REG_LOOP_MODE:     loop_mode         <= pwdata[0];
        REG_IRQ_ENABLE:    irq_enable        <= pwdata[0];
        REG_PERIOD_RELOAD: period_reload     <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_SAMPLE_ADDR:   prdata = {24'd0, sample_addr_latch};
      REG_SAMPLE_LEN:    prdata = {24'd0, sample_len_latch};
      REG_LOOP_MODE:     prdata = {31'd0, loop_mode};
      REG_IRQ_ENABLE:    prdata = {31'd0, irq_enable};
      REG_PERIOD_RELOAD: prdata = {23'd0, period_reload};
      default:           prdata = '0;
    endcase
  end

  assign s_tready = !m_tvalid || m_tready;
  assign in_xfer  = s_tvalid && s_tready;

  always_comb begin
    logic [7:0] dac_step;
    logic       sample_bit;
    st_next    = st;
    dac_step   = '0;
    sample_bit = 1'b0;
    case (s_tuser)
      OP_START: begin
        if (st.bytes_left == '0) begin
          st_next.read_pointer = {1'b1, sample_addr_latch, 6'd0};
          st_next.bytes_left   = {sample_len_latch, 4'b0001};
        end
      end
      OP_STOP: begin
        st_next.bytes_left = '0;
        st_next.dma_delay  = '0;
        st_next.stall_hold = 1'b0;
        st_next.addr_drive = 1'b0;
      end
      OP_TICK: begin
        // dma fetch: address on the next to last tick, byte on the last
        if (st.dma_delay != '0) begin
          st_next.dma_delay = st.dma_delay - 3'd1;
          if (st_next.dma_delay == 3'd1) begin
            st_next.addr_drive = 1'b1;
          end else if (st_next.dma_delay == '0) begin
            st_next.stall_hold    = 1'b0;
            st_next.addr_drive    = 1'b0;
            st_next.fetched_byte  = s_tdata;
            st_next.fetched_valid = 1'b1;
            st_next.bytes_left    = st.bytes_left - 12'd1;
            st_next.read_pointer  = st.read_pointer + 15'd1;
            if (st_next.bytes_left == '0) begin
              if (loop_mode) begin
                st_next.read_pointer = {1'b1, sample_addr_latch, 6'd0};
                st_next.bytes_left   = {sample_len_latch, 4'b0001};
              end else if (irq_enable) begin
                st_next.irq_pending = 1'b1;
              end
            end
          end
        end

        // output bit timer and dac update
        st_next.period_left = st.period_left - 9'd1;
        if (st_next.period_left == '0) begin
          if (st.shift_valid) begin
            sample_bit = st.shift_byte[st.bit_index];
            dac_step   = sample_bit ? ({1'b0, st.dac_value} + 8'd2)
                                    : ({1'b0, st.dac_value} - 8'd2);
            // steps past 127 or below 0 both land with bit 7 set
            if (!dac_step[7]) begin
              st_next.dac_value = dac_step[6:0];
            end
          end
          st_next.bit_index = st.bit_index + 3'd1;
          if (st_next.bit_index == '0) begin
            if (st_next.fetched_valid) begin
              st_next.shift_valid   = 1'b1;
              st_next.shift_byte    = st_next.fetched_byte;
              st_next.fetched_valid = 1'b0;
            end else begin
              st_next.shift_valid = 1'b0;
            end
          end
          st_next.period_left = period_reload;
        end

        if (st_next.bytes_left != '0 && !st_next.fetched_valid &&
            st_next.dma_delay == '0) begin
          st_next.stall_hold = 1'b1;
          st_next.dma_delay  = DMA_CYCLES;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_next.dac_level      = st.dac_value;
    res_next.cpu_stall      = st_next.stall_hold;
    res_next.dma_addr_valid = st_next.addr_drive;
    res_next.dma_addr       = BUS_HIGH | {1'b0, st_next.read_pointer};
    res_next.irq_flag       = st_next.irq_pending;
    res_next.busy_res       = st_next.bytes_left != '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= STATE_RESET;
      m_tvalid <= 1'b0;
    end else begin
      if (in_xfer) begin
        st <= st_next;
      end
      if (in_xfer) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      m_tdata <= {5'd0, res_next};
    end
  end

endmodule

### src/dmc_checker.sv
// port-level checks for the delta-modulation sample channel
// depends on assert_macros.svh; bound to delta_modulation_sample_channel_core
`include "assert_macros.svh"

module dmc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [4:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // a waiting result holds its value
  `CHK_ASSERT(a_result_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "result changed while stalled")

  // every input transfer gives a result on the next cycle
  `CHK_ASSERT(a_one_result, (s_tvalid && s_tready) |=> m_tvalid, "input transfer without result")

  // input side is held back only by a result that is not taken
  `CHK_ASSERT(a_ready_rule, s_tready == (!m_tvalid || m_tready), "input ready does not follow output side")

  // dma address is only driven inside a cpu stall
  `CHK_NEVER(a_addr_in_stall, m_tvalid && m_tdata[8] && !m_tdata[7], "dma address without cpu stall")

endmodule

bind delta_modulation_sample_channel_core dmc_checker u_dmc_checker (.*);

### bench/dmc_channel_checker.sv
// result checker for the delta-modulation sample channel: mirrors the register
// port, predicts one result per input transfer and compares result transfers
// in order; depends on dmc_pkg
module dmc_channel_checker
  import dmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] mem_data
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  input  logic        m_tvalid,
  input  logic        m_tready,
  // [6:0] dac_level, [7] cpu_stall, [8] dma_addr_valid, [24:9] dma_addr,
  // [25] irq_flag, [26] busy_res, [31:27] zero
  input  logic [31:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          results_owed
);

  localparam logic [14:0] SAMPLE_BASE = 15'h4000;
  localparam int PRINT_CAP = 40;

  // register mirror
  logic [7:0] addr_code;
  logic [7:0] len_code;
  logic       loop_on;
  logic       irq_on;
  logic [8:0] period_set;

  dmc_state_t  chan;
  dmc_result_t owed_results[$];
  int failures = 0;
  int owed_now = 0;
  int result_seq = 0;

  assign fail_count   = failures;
  assign results_owed = owed_now;

  task automatic report_failure(input string msg);
    failures++;
    if (failures <= PRINT_CAP) $display("dmc check: result %0d: %s", result_seq, msg);
  endtask

  // start only takes effect when no playback is running
  function automatic void load_sample();
    if (chan.bytes_left == '0) begin
      chan.read_pointer = SAMPLE_BASE + {1'b0, addr_code, 6'b0};
      chan.bytes_left   = {len_code, 4'b0} + 12'd1;
    end
  endfunction

  function automatic dmc_result_t step_channel(input logic [1:0] op, input logic [7:0] bus);
    dmc_result_t res;
    res.dac_level = chan.dac_value;
    case (op)
      OP_TICK: begin
        if (chan.dma_delay != '0) begin
          chan.dma_delay = chan.dma_delay - 3'd1;
          if (chan.dma_delay == 3'd1) begin
            chan.addr_drive = 1'b1;
          end else if (chan.dma_delay == '0) begin
            // fetch completes: byte is taken from the bus this cycle
            chan.stall_hold    = 1'b0;
            chan.addr_drive    = 1'b0;
            chan.fetched_byte  = bus;
            chan.fetched_valid = 1'b1;
            chan.bytes_left    = chan.bytes_left - 12'd1;
            chan.read_pointer  = chan.read_pointer + 15'd1;
            if (chan.bytes_left == '0) begin
              if (loop_on) load_sample();
              else if (irq_on) chan.irq_pending = 1'b1;
            end
          end
        end
        // a reload of zero wraps to 511 on the next tick
        chan.period_left = chan.period_left - 9'd1;
        if (chan.period_left == '0) begin
          if (chan.shift_valid) begin
            if (chan.shift_byte[chan.bit_index]) begin
              if (chan.dac_value <= 7'd125) chan.dac_value = chan.dac_value + 7'd2;
            end else if (chan.dac_value >= 7'd2) begin
              chan.dac_value = chan.dac_value - 7'd2;
            end
          end
          chan.bit_index = chan.bit_index + 3'd1;
          if (chan.bit_index == '0) begin
            chan.shift_valid = chan.fetched_valid;
            if (chan.fetched_valid) begin
              chan.shift_byte    = chan.fetched_byte;
              chan.fetched_valid = 1'b0;
            end
          end
          chan.period_left = period_set;
        end
        if (chan.bytes_left != '0 && !chan.fetched_valid && chan.dma_delay == '0) begin
          chan.stall_hold = 1'b1;
          chan.dma_delay  = DMA_CYCLES;
        end
      end
      OP_START: load_sample();
      OP_STOP: begin
        chan.bytes_left = '0;
        chan.dma_delay  = '0;
        chan.stall_hold = 1'b0;
        chan.addr_drive = 1'b0;
      end
      default: ;  // unused opcode leaves the state alone
    endcase
    res.cpu_stall      = chan.stall_hold;
    res.dma_addr_valid = chan.addr_drive;
    res.dma_addr       = BUS_HIGH | {1'b0, chan.read_pointer};
    res.irq_flag       = chan.irq_pending;
    res.busy_res       = (chan.bytes_left != '0);
    return res;
  endfunction

  always @(posedge clk) begin : track
    dmc_result_t got;
    dmc_result_t want;
    if (rst) begin
      addr_code  = '0;
      len_code   = '0;
      loop_on    = 1'b0;
      irq_on     = 1'b0;
      period_set = PERIOD_RESET;
      chan       = '0;
      chan.period_left = PERIOD_RESET;
      owed_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_SAMPLE_ADDR:   addr_code  = pwdata[7:0];
          REG_SAMPLE_LEN:    len_code   = pwdata[7:0];
          REG_LOOP_MODE:     loop_on    = pwdata[0];
          REG_IRQ_ENABLE:    irq_on     = pwdata[0];
          REG_PERIOD_RELOAD: period_set = pwdata[8:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[26:0];
        if (owed_results.size() == 0) begin
          report_failure($sformatf("transfer %h with nothing expected", m_tdata));
        end else begin
          want = owed_results.pop_front();
          if (got.dac_level !== want.dac_level)
            report_failure($sformatf("dac_level %0d, expected %0d",
                                     got.dac_level, want.dac_level));
          if (got.cpu_stall !== want.cpu_stall)
            report_failure($sformatf("cpu_stall %b, expected %b",
                                     got.cpu_stall, want.cpu_stall));
          if (got.dma_addr_valid !== want.dma_addr_valid)
            report_failure($sformatf("dma_addr_valid %b, expected %b",
                                     got.dma_addr_valid, want.dma_addr_valid));
          if (got.dma_addr !== want.dma_addr)
            report_failure($sformatf("dma_addr %h, expected %h",
                                     got.dma_addr, want.dma_addr));
          if (got.irq_flag !== want.irq_flag)
            report_failure($sformatf("irq_flag %b, expected %b",
                                     got.irq_flag, want.irq_flag));
          if (got.busy_res !== want.busy_res)
            report_failure($sformatf("busy_res %b, expected %b",
                                     got.busy_res, want.busy_res));
          if (m_tdata[31:27] !== '0)
            report_failure($sformatf("pad bits %b, expected zero", m_tdata[31:27]));
        end
        result_seq++;
      end
      // a result never leaves in the cycle its item enters
      if (s_tvalid && s_tready) owed_results.push_back(step_channel(s_tuser, s_tdata));
    end
    owed_now <= owed_results.size();
  end

endmodule

### bench/delta_modulation_sample_channel_core_tb.sv
// testbench top for delta_modulation_sample_channel_core: clock, reset, register
// writes, input and result stream traffic and the verdict
// depends on dmc_pkg, the core and dmc_channel_checker
module delta_modulation_sample_channel_core_tb;
  import dmc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASES = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] mem_data
  logic [1:0]  s_tuser = '0;   // [1:0] opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [6:0] dac_level, [7] cpu_stall, [8] dma_addr_valid, [24:9] dma_addr,
  // [25] irq_flag, [26] busy_res, [31:27] zero
  logic [31:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int   fail_count;
  int   results_owed;
  int   items_sent = 0;
  int   cycles = 0;
  logic hold_results = 1'b0;

  always #5 clk = ~clk;

  delta_modulation_sample_channel_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  dmc_channel_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("delta_modulation_sample_channel_core regression: fail");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] data, input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // drain every owed result, then give the result register a moment
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // back-to-back writes keep psel high; penable drops after each access
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
  endtask

  task automatic apply_settings(input logic [7:0] addr_code, input logic [7:0] len_code,
                                input logic loop_on, input logic irq_on,
                                input logic [8:0] period);
    write_reg(REG_SAMPLE_ADDR, {24'd0, addr_code});
    write_reg(REG_SAMPLE_LEN, {24'd0, len_code});
    write_reg(REG_LOOP_MODE, {31'd0, loop_on});
    write_reg(REG_IRQ_ENABLE, {31'd0, irq_on});
    write_reg(REG_PERIOD_RELOAD, {23'd0, period});
    psel   <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin : stimulus
    int         n;
    int         r;
    int         gap_top;
    int         data_mode;
    int         pick;
    logic       quiet;
    logic [1:0] op;
    logic [7:0] data;
    logic [8:0] period;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, then a one-byte sample from the top of memory
    send_item(OP_UNUSED, 8'h00, 0);
    send_item(OP_TICK, 8'hFF, 1);
    send_item(OP_STOP, 8'h00, 0);
    wait_idle();
    apply_settings(8'hFF, 8'h00, 1'b0, 1'b1, 9'd1);
    send_item(OP_START, 8'h00, 0);
    send_item(OP_START, 8'hFF, 0);  // ignored while playing
    repeat (4) send_item(OP_TICK, 8'hFF, $urandom_range(0, 2));
    repeat (12) send_item(OP_TICK, 8'h00, 0);
    send_item(OP_UNUSED, 8'hA5, 3);
    send_item(OP_STOP, 8'h5A, 0);
    send_item(OP_START, 8'h00, 0);
    send_item(OP_TICK, 8'hFF, 0);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        // long sample near the top of the pointer range so the address wraps
        0: apply_settings(8'hFF, 8'h07, 1'b0, 1'b0, 9'd1);
        1: apply_settings(8'h00, 8'hFF, 1'b1, 1'b0, 9'd511);
        2: apply_settings(8'($urandom_range(0, 255)), 8'h00, 1'b1, 1'b1, 9'd0);
        default: begin
          pick = $urandom_range(0, 9);
          if (pick < 6) period = 9'($urandom_range(1, 4));
          else if (pick == 6) period = 9'd0;
          else if (pick == 7) period = 9'd511;
          else period = 9'($urandom_range(1, 511));
          apply_settings(8'($urandom_range(0, 255)),
                         ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 2))
                                                    : 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), period);
        end
      endcase
      quiet     = (ph == 0);
      n         = quiet ? 580 : 30;
      gap_top   = ($urandom_range(0, 3) == 0) ? 0 : 8;
      data_mode = quiet ? 1 : $urandom_range(0, 2);
      if (quiet || $urandom_range(0, 1)) send_item(OP_STOP, 8'($urandom_range(0, 255)), 0);
      send_item(OP_START, 8'($urandom_range(0, 255)), $urandom_range(0, gap_top));
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(0, 99);
        if (quiet) op = (r < 96) ? OP_TICK : (r < 98) ? OP_START : OP_UNUSED;
        else op = (r < 84) ? OP_TICK : (r < 91) ? OP_START : (r < 96) ? OP_STOP : OP_UNUSED;
        // biased bytes push the dac into its rails
        case (data_mode)
          1: data = ($urandom_range(0, 3) != 0) ? 8'hFF : 8'($urandom_range(0, 255));
          2: data = ($urandom_range(0, 3) != 0) ? 8'h00 : 8'($urandom_range(0, 255));
          default: data = 8'($urandom_range(0, 255));
        endcase
        send_item(op, data, $urandom_range(0, gap_top));
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("delta_modulation_sample_channel_core regression: pass");
    end else begin
      $display("delta_modulation_sample_channel_core regression: fail");
    end
    $finish;
  end

  initial begin : result_sink
    int   stall;
    int   run_left;
    logic eager;
    run_left = 0;
    eager    = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (run_left == 0) begin
        eager    = ($urandom_range(0, 2) == 0);
        run_left = $urandom_range(10, 60);
      end
      run_left--;
      stall = eager ? 0 : $urandom_range(0, 8);
      if (stall > 0 || hold_results) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold_results) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // long hold-off on the result side so the core backs up onto its input
  initial begin : sink_hold_off
    while (items_sent < 200) @(posedge clk);
    hold_results <= 1'b1;
    repeat (64) @(posedge clk);
    hold_results <= 1'b0;
  end

endmodule

### sim.f
+incdir+src
src/dmc_pkg.sv
src/delta_modulation_sample_channel_core.sv
src/dmc_checker.sv
bench/dmc_channel_checker.sv
bench/delta_modulation_sample_channel_core_tb.sv
